// File: hw/rtl/kvtlp_pkg.sv
// shared types, constants and key matching for the telemetry line parser
package kvtlp_pkg;

  localparam int unsigned MaxLineCharsDef = 159;
  localparam int unsigned KeyCharsDef     = 11;
  localparam int unsigned ValueCharsDef   = 23;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChTilde = 8'h7E;

  localparam logic [23:0] KeyRpm     = "RPM";
  localparam logic [23:0] KeyMap     = "MAP";
  localparam logic [23:0] KeyTps     = "TPS";
  localparam logic [23:0] KeyClt     = "CLT";
  localparam logic [23:0] KeyIat     = "IAT";
  localparam logic [23:0] KeyAfr     = "AFR";
  localparam logic [23:0] KeyBat     = "BAT";
  localparam logic [31:0] KeyVbat    = "VBAT";
  localparam logic [55:0] KeyBattery = "BATTERY";

  // scaling bounds: below 50 for mixture, below 30 for battery
  localparam logic [31:0] AfrLimit = 32'd49;
  localparam logic [31:0] BatLimit = 32'd29;
  localparam logic [6:0]  Hundred  = 7'd100;
  localparam logic [6:0]  FracMax  = 7'd99;

  typedef enum logic [0:0] {
    PH_KEY,
    PH_VALUE
  } phase_e;

  typedef enum logic [1:0] {
    NUM_LEAD,
    NUM_INT,
    NUM_FRAC,
    NUM_DONE
  } num_e;

  typedef enum logic [2:0] {
    SLOT_RPM,
    SLOT_MAP,
    SLOT_TPS,
    SLOT_CLT,
    SLOT_IAT,
    SLOT_AFR,
    SLOT_BAT,
    SLOT_NONE
  } slot_e;

  // one transfer's outcome, handed from the lexer to the commit stage
  typedef struct packed {
    logic        end_line;
    logic        bad;
    logic        fin;
    slot_e       slot;
    logic        neg;
    logic        fracnz;
    logic [6:0]  frac;
    logic [31:0] acc;
  } ev_t;

  typedef struct packed {
    logic [31:0] bat;
    logic [31:0] afr;
    logic [15:0] iat;
    logic [15:0] clt;
    logic [15:0] tps;
    logic [15:0] map;
    logic [15:0] rpm;
  } readings_t;

  typedef struct packed {
    readings_t  rd;
    logic       accepted;
  } res_t;

  localparam int unsigned ResW   = $bits(res_t);
  localparam int unsigned TdataW = ((ResW + 7) / 8) * 8;

  function automatic slot_e match_key(input logic [6:0][7:0] k, input logic [2:0] len,
                                      input logic short_key);
    slot_e s;
    s = SLOT_NONE;
    if (short_key) begin
      if (len == 3'd3) begin
        if ({k[0], k[1], k[2]} == KeyRpm) s = SLOT_RPM;
        else if ({k[0], k[1], k[2]} == KeyMap) s = SLOT_MAP;
        else if ({k[0], k[1], k[2]} == KeyTps) s = SLOT_TPS;
        else if ({k[0], k[1], k[2]} == KeyClt) s = SLOT_CLT;
        else if ({k[0], k[1], k[2]} == KeyIat) s = SLOT_IAT;
        else if ({k[0], k[1], k[2]} == KeyAfr) s = SLOT_AFR;
        else if ({k[0], k[1], k[2]} == KeyBat) s = SLOT_BAT;
      end else if (len == 3'd4) begin
        if ({k[0], k[1], k[2], k[3]} == KeyVbat) s = SLOT_BAT;
      end else if (len == 3'd7) begin
        if ({k[0], k[1], k[2], k[3], k[4], k[5], k[6]} == KeyBattery) s = SLOT_BAT;
      end
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/kvtlp_lexer.sv
// per-byte key/value lexer and number accumulator, registers one event per transfer
module kvtlp_lexer #(
  parameter int unsigned MaxLineChars = kvtlp_pkg::MaxLineCharsDef,
  parameter int unsigned KeyChars     = kvtlp_pkg::KeyCharsDef,
  parameter int unsigned ValueChars   = kvtlp_pkg::ValueCharsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       byte_i,
  input  logic             end_i,
  output logic             ev_valid_o,
  input  logic             ev_ready_i,
  output kvtlp_pkg::ev_t   ev_o
);

  localparam int unsigned PosW  = $clog2(MaxLineChars + 1);
  localparam int unsigned KlenW = $clog2(KeyChars + 1);
  localparam int unsigned KidxW = $clog2(KeyChars);
  localparam int unsigned VlenW = $clog2(ValueChars + 1);

  kvtlp_pkg::phase_e phase_q, phase_d;
  kvtlp_pkg::num_e   sub_q, sub_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [KlenW-1:0]  klen_q, klen_d;
  logic [VlenW-1:0]  vlen_q, vlen_d;
  logic [31:0]       acc_q, acc_d;
  logic [6:0]        frac_q, frac_d;
  logic              neg_q, neg_d;
  logic              fracnz_q, fracnz_d;
  logic [PosW-1:0]   pos_q;
  logic              bad_q;
  logic [7:0]        key_text_q [KeyChars];
  logic              ev_valid_q;
  kvtlp_pkg::ev_t    ev_q;

  logic              fire;
  logic              printable, sep, parse, is_digit, kwr, sep_fin, pclear, fin, clear;
  logic [7:0]        uc;
  logic [3:0]        d;
  logic [6:0][7:0]   k_head;
  kvtlp_pkg::slot_e  slot;

  assign fire       = in_valid_i && in_ready_o;
  assign in_ready_o = !ev_valid_q || ev_ready_i;

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      k_head[i] = key_text_q[i];
    end
  end

  assign slot = kvtlp_pkg::match_key(k_head, klen_q[2:0], klen_q <= KlenW'(7));

  always_comb begin
    printable = ((byte_i >= kvtlp_pkg::ChSpace) && (byte_i <= kvtlp_pkg::ChTilde)) ||
                (byte_i == kvtlp_pkg::ChTab) || (byte_i == kvtlp_pkg::ChCr) ||
                (byte_i == kvtlp_pkg::ChLf);
    sep       = (byte_i == kvtlp_pkg::ChComma) || (byte_i == kvtlp_pkg::ChCr) ||
                (byte_i == kvtlp_pkg::ChLf);
    parse     = pos_q < PosW'(MaxLineChars);
    is_digit  = (byte_i >= "0") && (byte_i <= "9");
    d         = is_digit ? 4'(byte_i - "0") : 4'd0;
    uc        = ((byte_i >= "a") && (byte_i <= "z")) ? byte_i - 8'd32 : byte_i;

    phase_d  = phase_q;
    sub_d    = sub_q;
    cnt_d    = cnt_q;
    klen_d   = klen_q;
    vlen_d   = vlen_q;
    acc_d    = acc_q;
    frac_d   = frac_q;
    neg_d    = neg_q;
    fracnz_d = fracnz_q;
    kwr      = 1'b0;
    sep_fin  = 1'b0;
    pclear   = 1'b0;

    if (parse) begin
      if (phase_q == kvtlp_pkg::PH_KEY) begin
        if (byte_i == kvtlp_pkg::ChEqual) begin
          phase_d = kvtlp_pkg::PH_VALUE;
        end else if (sep) begin
          pclear = 1'b1;
        end else if ((((uc >= "A") && (uc <= "Z")) || is_digit) &&
                     (klen_q < KlenW'(KeyChars))) begin
          kwr    = 1'b1;
          klen_d = klen_q + KlenW'(1);
        end
      end else if (sep) begin
        sep_fin = 1'b1;
      end else if (vlen_q < VlenW'(ValueChars)) begin
        vlen_d = vlen_q + VlenW'(1);
        case (sub_q)
          kvtlp_pkg::NUM_LEAD: begin
            if ((byte_i == kvtlp_pkg::ChSpace) || (byte_i == kvtlp_pkg::ChTab)) begin
              sub_d = kvtlp_pkg::NUM_LEAD;
            end else if (byte_i == kvtlp_pkg::ChMinus) begin
              neg_d = 1'b1;
              sub_d = kvtlp_pkg::NUM_INT;
            end else if (is_digit) begin
              acc_d = 32'(d);
              sub_d = kvtlp_pkg::NUM_INT;
            end else if (byte_i == kvtlp_pkg::ChDot) begin
              sub_d = kvtlp_pkg::NUM_FRAC;
            end else begin
              sub_d = kvtlp_pkg::NUM_DONE;
            end
          end
          kvtlp_pkg::NUM_INT: begin
            if (is_digit) begin
              acc_d = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + 32'(d);
            end else if (byte_i == kvtlp_pkg::ChDot) begin
              sub_d = kvtlp_pkg::NUM_FRAC;
            end else begin
              sub_d = kvtlp_pkg::NUM_DONE;
            end
          end
          kvtlp_pkg::NUM_FRAC: begin
            if (is_digit) begin
              // only the first two fraction digits enter frac; any nonzero digit sets fracnz
              if (cnt_q == 2'd0) begin
                frac_d = 7'(d) * 7'd10;
                cnt_d  = 2'd1;
              end else if (cnt_q == 2'd1) begin
                frac_d = frac_q + 7'(d);
                cnt_d  = 2'd2;
              end
              if (d != 4'd0) fracnz_d = 1'b1;
            end else begin
              sub_d = kvtlp_pkg::NUM_DONE;
            end
          end
          default: begin
            sub_d = sub_q;
          end
        endcase
      end
    end

    // an open pair is closed at end of line as well as by a separator
    fin   = sep_fin || (end_i && (phase_d == kvtlp_pkg::PH_VALUE));
    clear = pclear || fin || end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= kvtlp_pkg::PH_KEY;
      sub_q      <= kvtlp_pkg::NUM_LEAD;
      cnt_q      <= '0;
      klen_q     <= '0;
      vlen_q     <= '0;
      acc_q      <= '0;
      frac_q     <= '0;
      neg_q      <= 1'b0;
      fracnz_q   <= 1'b0;
      pos_q      <= '0;
      bad_q      <= 1'b0;
      ev_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        ev_valid_q <= 1'b1;
      end else if (ev_ready_i) begin
        ev_valid_q <= 1'b0;
      end
      if (fire) begin
        if (clear) begin
          phase_q  <= kvtlp_pkg::PH_KEY;
          sub_q    <= kvtlp_pkg::NUM_LEAD;
          cnt_q    <= '0;
          klen_q   <= '0;
          vlen_q   <= '0;
          acc_q    <= '0;
          frac_q   <= '0;
          neg_q    <= 1'b0;
          fracnz_q <= 1'b0;
        end else begin
          phase_q  <= phase_d;
          sub_q    <= sub_d;
          cnt_q    <= cnt_d;
          klen_q   <= klen_d;
          vlen_q   <= vlen_d;
          acc_q    <= acc_d;
          frac_q   <= frac_d;
          neg_q    <= neg_d;
          fracnz_q <= fracnz_d;
        end
        if (end_i) begin
          pos_q <= '0;
          bad_q <= 1'b0;
        end else begin
          if (parse) pos_q <= pos_q + PosW'(1);
          bad_q <= bad_q || !printable;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && kwr) begin
      key_text_q[klen_q[KidxW-1:0]] <= uc;
    end
    if (fire) begin
      ev_q.end_line <= end_i;
      ev_q.bad      <= bad_q || !printable;
      ev_q.fin      <= fin;
      ev_q.slot     <= slot;
      ev_q.neg      <= neg_d;
      ev_q.fracnz   <= fracnz_d;
      ev_q.frac     <= frac_d;
      ev_q.acc      <= acc_d;
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

  a_counters_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= PosW'(MaxLineChars)) && (klen_q <= KlenW'(KeyChars)) &&
    (vlen_q <= VlenW'(ValueChars)))
    else $error("lexer counter past its limit");

  a_frac_hundredths: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_q && ev_q.fin) |-> (ev_q.frac <= kvtlp_pkg::FracMax))
    else $error("fraction hundredths out of range");

endmodule

// File: hw/rtl/kvtlp_commit.sv
// scales closed pairs into staged readings, commits on line end, holds the result register
module kvtlp_commit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ev_valid_i,
  output logic                          ev_ready_o,
  input  kvtlp_pkg::ev_t                ev_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kvtlp_pkg::ResW-1:0]    out_data_o
);

  kvtlp_pkg::readings_t staged_q, staged_n, committed_q, committed_n;
  logic                 matched_q, matched_n;
  logic                 out_valid_q;
  kvtlp_pkg::res_t      res_q;

  logic        fire, accepted, afr_ok, bat_ok;
  logic [31:0] ival, ival_x10, afr_v, bat_v;
  logic [12:0] hund;

  assign ev_ready_o = !(ev_i.end_line && out_valid_q && !out_ready_i);
  assign fire       = ev_valid_i && ev_ready_o;

  always_comb begin
    ival     = ev_i.neg ? 32'd0 - ev_i.acc : ev_i.acc;
    ival_x10 = {ival[28:0], 3'b000} + {ival[30:0], 1'b0};
    // small magnitudes only, so a 6-bit by 7-bit product is enough
    hund     = 13'(ev_i.acc[5:0]) * 13'(kvtlp_pkg::Hundred) + 13'(ev_i.frac);
    afr_ok   = !ev_i.neg && (ev_i.acc <= kvtlp_pkg::AfrLimit) &&
               ((ev_i.acc != 32'd0) || ev_i.fracnz);
    bat_ok   = !ev_i.neg && (ev_i.acc <= kvtlp_pkg::BatLimit) &&
               ((ev_i.acc != 32'd0) || ev_i.fracnz);
    afr_v    = afr_ok ? 32'(hund) : ival;
    bat_v    = bat_ok ? 32'(hund) : ival_x10;

    staged_n  = staged_q;
    matched_n = matched_q;
    if (ev_i.fin && (ev_i.slot != kvtlp_pkg::SLOT_NONE)) begin
      matched_n = 1'b1;
      unique case (ev_i.slot)
        kvtlp_pkg::SLOT_RPM: staged_n.rpm = ival[15:0];
        kvtlp_pkg::SLOT_MAP: staged_n.map = ival[15:0];
        kvtlp_pkg::SLOT_TPS: staged_n.tps = ival[15:0];
        kvtlp_pkg::SLOT_CLT: staged_n.clt = ival[15:0];
        kvtlp_pkg::SLOT_IAT: staged_n.iat = ival[15:0];
        kvtlp_pkg::SLOT_AFR: staged_n.afr = afr_v;
        kvtlp_pkg::SLOT_BAT: staged_n.bat = bat_v;
        default:             staged_n     = staged_q;
      endcase
    end
    accepted    = !ev_i.bad && matched_n;
    committed_n = accepted ? staged_n : committed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_q    <= '0;
      committed_q <= '0;
      matched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire && ev_i.end_line) begin
        committed_q <= committed_n;
        staged_q    <= committed_n;
        matched_q   <= 1'b0;
      end else if (fire) begin
        staged_q  <= staged_n;
        matched_q <= matched_n;
      end
      if (fire && ev_i.end_line) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && ev_i.end_line) begin
      res_q.rd       <= committed_n;
      res_q.accepted <= accepted;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  a_reject_keeps_committed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ev_i.end_line && !accepted) |=> $stable(committed_q))
    else $error("rejected line changed committed readings");

  a_line_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ev_i.end_line) |=> (!matched_q && (staged_q == committed_q)))
    else $error("staged state not reloaded at line end");

endmodule

// File: hw/rtl/key_value_telemetry_line_parser.sv
// top level of the key/value telemetry line parser
//
//  channel  | dir | payload                                         | moves
//  s_axis   | in  | tdata[7:0] data byte, tlast line end            | one character
//  m_axis   | out | tdata: accepted, rpm, map, tps, clt, iat, afr,  | one result per line
//           |     |        battery                                  |
//
// one transfer per cycle unless commit stalls; the lexer state updates in the accept cycle
// a line's result passes the lexer event register, then the commit result register
// rate is set by the lexer-to-commit event register, one event per cycle unless commit stalls
// reset clears parser state and both staged and committed readings to zero
// a stalled result holds the input only once a second line end reaches the commit stage
module key_value_telemetry_line_parser #(
  parameter int unsigned MAX_LINE_CHARS = kvtlp_pkg::MaxLineCharsDef,
  parameter int unsigned KEY_CHARS      = kvtlp_pkg::KeyCharsDef,
  parameter int unsigned VALUE_CHARS    = kvtlp_pkg::ValueCharsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tlast,  // line_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] accepted, [16:1] engine_speed, [32:17] manifold_pressure, [48:33] throttle,
  // [64:49] coolant_temp, [80:65] intake_temp, [112:81] mixture_ratio_x100,
  // [144:113] battery_volts_x100, rest zero
  output logic [kvtlp_pkg::TdataW-1:0]    m_axis_tdata
);

  logic                           ev_valid, ev_ready;
  kvtlp_pkg::ev_t                 ev;
  logic [kvtlp_pkg::ResW-1:0]     res;

  kvtlp_lexer #(
    .MaxLineChars (MAX_LINE_CHARS),
    .KeyChars     (KEY_CHARS),
    .ValueChars   (VALUE_CHARS)
  ) u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .byte_i     (s_axis_tdata),
    .end_i      (s_axis_tlast),
    .ev_valid_o (ev_valid),
    .ev_ready_i (ev_ready),
    .ev_o       (ev)
  );

  kvtlp_commit u_commit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid),
    .ev_ready_o  (ev_ready),
    .ev_i        (ev),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {(kvtlp_pkg::TdataW - kvtlp_pkg::ResW)'(0), res};

endmodule
